/* rtl/bmsp_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes and types of the battery monitor spi slave
package bmsp_pkg;

   localparam int CHIP_COUNT    = 8;
   localparam int CELL_CHANNELS = 12;
   localparam int AUX_CHANNELS  = 6;
   localparam int CFG_DEPTH     = CHIP_COUNT * 6;
   localparam int CELL_DEPTH    = CHIP_COUNT * CELL_CHANNELS;
   localparam int AUX_DEPTH     = CHIP_COUNT * AUX_CHANNELS;
   localparam int CFG_AW        = $clog2(CFG_DEPTH);
   localparam int CELL_AW       = $clog2(CELL_DEPTH);
   localparam int AUX_AW        = $clog2(AUX_DEPTH);
   localparam int WIN_AW        = 10;

   localparam logic [WIN_AW-1:0] CELL_BASE = WIN_AW'(CFG_DEPTH);
   localparam logic [WIN_AW-1:0] AUX_BASE  = WIN_AW'(CFG_DEPTH + 2 * CELL_DEPTH);
   localparam logic [WIN_AW-1:0] WIN_END   = WIN_AW'(CFG_DEPTH + 2 * CELL_DEPTH + 2 * AUX_DEPTH);

   localparam logic [1:0] ITEM_BYTE      = 2'd0;
   localparam logic [1:0] ITEM_TICK      = 2'd1;
   localparam logic [1:0] ITEM_LOAD_CELL = 2'd2;
   localparam logic [1:0] ITEM_LOAD_AUX  = 2'd3;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_PEC       = 3'd1;
   localparam logic [2:0] ERR_ADDR      = 3'd2;
   localparam logic [2:0] ERR_CMD       = 3'd3;
   localparam logic [2:0] ERR_NOT_READY = 3'd4;

   localparam logic [1:0] CSR_CELL_CODE = 2'd0;
   localparam logic [1:0] CSR_AUX_CODE  = 2'd1;
   localparam logic [1:0] CSR_CONV_MS   = 2'd2;

   localparam logic [1:0] PH_CMD  = 2'd0;
   localparam logic [1:0] PH_RECV = 2'd1;
   localparam logic [1:0] PH_SEND = 2'd2;

   localparam logic [15:0] CLR_CELL_CMD = 16'h0711;
   localparam logic [15:0] CLR_AUX_CMD  = 16'h0712;
   localparam logic [7:0]  ADDR_MIN     = 8'h80;
   localparam logic [7:0]  OP_WRCFG     = 8'h01;
   localparam logic [7:0]  OP_RDCFG     = 8'h02;
   localparam logic [7:0]  OP_CELL_LO   = 8'h04;
   localparam logic [7:0]  OP_CELL_HI   = 8'h0A;
   localparam logic [7:0]  OP_AUX_LO    = 8'h0C;
   localparam logic [7:0]  OP_AUX_HI    = 8'h0E;

   localparam logic [14:0] PEC_SEED = 15'd16;
   localparam logic [14:0] PEC_POLY = 15'h4599;

   typedef struct packed {
      logic       init;
      logic       go;
      logic [7:0] data;
   } crc_ctl_type;

   typedef struct packed {
      logic        busy;
      logic [14:0] rem;
   } crc_sts_type;

endpackage

/* rtl/bmsp_ram.sv */
`timescale 1ns / 1ps
// generic single write port ram with registered read
module bmsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/bmsp_crc.sv */
`timescale 1ns / 1ps
// bit-serial pec15 unit; busy while it shifts in a byte
module bmsp_crc (
   input  logic                  clock,
   input  logic                  reset,
   input  bmsp_pkg::crc_ctl_type ctl,
   output bmsp_pkg::crc_sts_type sts
);
   import bmsp_pkg::*;

   logic [14:0] rem_ff, rem_in;
   logic [7:0]  data_ff, data_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        fb;

   always_comb begin
      rem_in  = rem_ff;
      data_in = data_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fb      = data_ff[7] ^ rem_ff[14];
      if (ctl.init) begin
         rem_in = PEC_SEED;
      end
      if (ctl.go) begin
         data_in = ctl.data;
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {rem_ff[13:0], 1'b0} ^ (fb ? PEC_POLY : 15'd0);
         data_in = {data_ff[6:0], 1'b0};
         cnt_in  = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      data_ff <= data_in;
   end

   assign sts.busy = busy_ff;
   assign sts.rem  = rem_ff;
endmodule

/* rtl/battery_monitor_spi_slave.sv */
`timescale 1ns / 1ps
// battery monitor spi slave: frame sequencer, measurement stores and pec unit
// tick and load items run in S_EXEC, plain serial bytes in S_EXEC or, to send a window byte, S_EXEC, S_SRD, S_SRDW
// a frame-closing command byte runs the command pec through the bit-serial crc unit
// (S_CPHI, S_CPW1, S_CPW2, S_DEC); a read command adds six window bytes, each read and then fed to the crc
// one transaction at a time, busy high until its result strobe; results cannot be stalled
// synchronous reset clears control state and the configuration and store valid bits, and restores the csr defaults
module battery_monitor_spi_slave (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_mosi_byte,
   input  logic [3:0]  req_chip_index,
   input  logic [3:0]  req_channel_index,
   input  logic [15:0] req_sample_value,
   output logic        rsp_valid,
   output logic        rsp_miso_valid,
   output logic [7:0]  rsp_miso_byte,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_command_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bmsp_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_EXEC = 4'd1;
   localparam logic [3:0] S_SRD  = 4'd2;
   localparam logic [3:0] S_SRDW = 4'd3;
   localparam logic [3:0] S_CPHI = 4'd4;
   localparam logic [3:0] S_CPW1 = 4'd5;
   localparam logic [3:0] S_CPW2 = 4'd6;
   localparam logic [3:0] S_DEC  = 4'd7;
   localparam logic [3:0] S_WRD  = 4'd8;
   localparam logic [3:0] S_WRDW = 4'd9;
   localparam logic [3:0] S_WCRC = 4'd10;

   localparam logic [1:0] RG_CFG  = 2'd0;
   localparam logic [1:0] RG_CELL = 2'd1;
   localparam logic [1:0] RG_AUX  = 2'd2;
   localparam logic [1:0] RG_NONE = 2'd3;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  item_ff, item_in;
   logic [7:0]  byte_ff, byte_in;
   logic [3:0]  chip_ff, chip_in;
   logic [3:0]  chan_ff, chan_in;
   logic [15:0] sample_ff, sample_in;
   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic        inpec_ff, inpec_in;
   logic [15:0] cmdbuf_ff, cmdbuf_in;
   logic [15:0] pec_ff, pec_in;
   logic [WIN_AW-1:0] wb_ff, wb_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [7:0]  cell_wait_ff, cell_wait_in;
   logic [7:0]  aux_wait_ff, aux_wait_in;
   logic [CFG_DEPTH-1:0]  cfg_vld_ff, cfg_vld_in;
   logic [CELL_DEPTH-1:0] cell_vld_ff, cell_vld_in;
   logic [AUX_DEPTH-1:0]  aux_vld_ff, aux_vld_in;
   logic [15:0] cell_code_ff, cell_code_in;
   logic [15:0] aux_code_ff, aux_code_in;
   logic [7:0]  conv_ms_ff, conv_ms_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_mv_ff, rsp_mv_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [2:0]  rsp_err_ff, rsp_err_in;
   logic        rsp_done_ff, rsp_done_in;
   logic [1:0]  rd_region_ff, rd_region_in;
   logic        rd_sel_ff, rd_sel_in;
   logic        rd_vld_ff, rd_vld_in;

   logic [2:0]        rd_idx;
   logic [WIN_AW-1:0] win_addr, cell_off, aux_off, recv_addr;
   logic [CFG_AW-1:0] cfg_raddr, cfg_waddr;
   logic [CELL_AW-1:0] cell_raddr, cell_waddr;
   logic [AUX_AW-1:0] aux_raddr, aux_waddr;
   logic [7:0]  cell_lidx, aux_lidx;
   logic        cfg_we, cell_we, aux_we;
   logic [7:0]  cfg_rdata;
   logic [15:0] cell_rdata, aux_rdata;
   logic [7:0]  win_byte;
   logic        cell_load_ok, aux_load_ok;
   logic        adv, finish;
   logic [2:0]  pos_next, limit;
   logic [7:0]  cmd_hi, cmd_lo;
   logic [3:0]  ic;
   logic [2:0]  op_cell, op_aux;
   logic [WIN_AW-1:0] cfg_base, cell_base, aux_base;
   bmsp_pkg::crc_ctl_type crc_ctl;
   bmsp_pkg::crc_sts_type crc_sts;

   bmsp_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .sts   (crc_sts)
   );

   bmsp_ram #(.WIDTH(8), .DEPTH(CFG_DEPTH)) u_cfg_ram (
      .clock   (clock),
      .wr_en   (cfg_we),
      .wr_addr (cfg_waddr),
      .wr_data (byte_ff),
      .rd_addr (cfg_raddr),
      .rd_data (cfg_rdata)
   );

   bmsp_ram #(.WIDTH(16), .DEPTH(CELL_DEPTH)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (sample_ff),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   bmsp_ram #(.WIDTH(16), .DEPTH(AUX_DEPTH)) u_aux_ram (
      .clock   (clock),
      .wr_en   (aux_we),
      .wr_addr (aux_waddr),
      .wr_data (sample_ff),
      .rd_addr (aux_raddr),
      .rd_data (aux_rdata)
   );

   // window read address and region
   always_comb begin
      rd_idx     = (state_ff == S_SRD) ? pos_ff : cnt_ff;
      win_addr   = wb_ff + WIN_AW'(rd_idx);
      cell_off   = win_addr - CELL_BASE;
      aux_off    = win_addr - AUX_BASE;
      cfg_raddr  = win_addr[CFG_AW-1:0];
      cell_raddr = cell_off[CELL_AW:1];
      aux_raddr  = aux_off[AUX_AW:1];
      rd_sel_in  = 1'b0;
      rd_vld_in  = 1'b0;
      if (win_addr < CELL_BASE) begin
         rd_region_in = RG_CFG;
      end else if (win_addr < AUX_BASE) begin
         rd_region_in = RG_CELL;
      end else if (win_addr < WIN_END) begin
         rd_region_in = RG_AUX;
      end else begin
         rd_region_in = RG_NONE;
      end
      case (rd_region_in)
         RG_CFG: begin
            rd_vld_in = cfg_vld_ff[cfg_raddr];
         end
         RG_CELL: begin
            rd_vld_in = cell_vld_ff[cell_raddr];
            rd_sel_in = cell_off[0];
         end
         RG_AUX: begin
            rd_vld_in = aux_vld_ff[aux_raddr];
            rd_sel_in = aux_off[0];
         end
         default: begin
            rd_vld_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (rd_region_ff)
         RG_CFG:  win_byte = rd_vld_ff ? cfg_rdata : 8'd0;
         RG_CELL: win_byte = !rd_vld_ff ? 8'd0 : (rd_sel_ff ? cell_rdata[15:8] : cell_rdata[7:0]);
         RG_AUX:  win_byte = !rd_vld_ff ? 8'd0 : (rd_sel_ff ? aux_rdata[15:8] : aux_rdata[7:0]);
         default: win_byte = 8'd0;
      endcase
   end

   // write addresses
   always_comb begin
      recv_addr    = wb_ff + WIN_AW'(pos_ff);
      cfg_waddr    = recv_addr[CFG_AW-1:0];
      cell_lidx    = 8'({chip_ff, 3'b000}) + 8'({chip_ff, 2'b00}) + 8'(chan_ff);
      aux_lidx     = 8'({chip_ff, 2'b00}) + 8'({chip_ff, 1'b0}) + 8'(chan_ff);
      cell_waddr   = cell_lidx[CELL_AW-1:0];
      aux_waddr    = aux_lidx[AUX_AW-1:0];
      cell_load_ok = ({1'b0, chip_ff} < 5'(CHIP_COUNT)) && (chan_ff < 4'(CELL_CHANNELS));
      aux_load_ok  = ({1'b0, chip_ff} < 5'(CHIP_COUNT)) && (chan_ff < 4'(AUX_CHANNELS));
   end

   // command decode fields
   always_comb begin
      cmd_hi    = cmdbuf_ff[15:8];
      cmd_lo    = cmdbuf_ff[7:0];
      ic        = cmd_hi[6:3];
      op_cell   = 3'(cmd_lo[3:0] - 4'(OP_CELL_LO));
      op_aux    = 3'(cmd_lo[3:0] - 4'(OP_AUX_LO));
      cfg_base  = WIN_AW'({ic, 2'b00}) + WIN_AW'({ic, 1'b0});
      cell_base = CELL_BASE + WIN_AW'({cfg_base, 2'b00})
                  + WIN_AW'({op_cell, 1'b0}) + WIN_AW'(op_cell);
      aux_base  = AUX_BASE + WIN_AW'({cfg_base, 1'b0})
                  + WIN_AW'({op_aux, 1'b0}) + WIN_AW'(op_aux);
      pos_next  = pos_ff + 3'd1;
      limit     = (phase_ff == PH_CMD) ? 3'd2 : 3'd6;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      byte_in      = byte_ff;
      chip_in      = chip_ff;
      chan_in      = chan_ff;
      sample_in    = sample_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      inpec_in     = inpec_ff;
      cmdbuf_in    = cmdbuf_ff;
      pec_in       = pec_ff;
      wb_in        = wb_ff;
      cnt_in       = cnt_ff;
      cell_wait_in = cell_wait_ff;
      aux_wait_in  = aux_wait_ff;
      cfg_vld_in   = cfg_vld_ff;
      cell_vld_in  = cell_vld_ff;
      aux_vld_in   = aux_vld_ff;
      cell_code_in = cell_code_ff;
      aux_code_in  = aux_code_ff;
      conv_ms_in   = conv_ms_ff;
      rsp_mv_in    = rsp_mv_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_done_in  = rsp_done_ff;
      cfg_we       = 1'b0;
      cell_we      = 1'b0;
      aux_we       = 1'b0;
      crc_ctl      = '0;
      adv          = 1'b0;
      finish       = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CELL_CODE: cell_code_in = csr_data;
            CSR_AUX_CODE:  aux_code_in  = csr_data;
            CSR_CONV_MS:   conv_ms_in   = csr_data[7:0];
            default:       conv_ms_in   = conv_ms_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in     = req_command;
               byte_in     = req_mosi_byte;
               chip_in     = req_chip_index;
               chan_in     = req_channel_index;
               sample_in   = req_sample_value;
               rsp_mv_in   = 1'b0;
               rsp_byte_in = 8'd0;
               rsp_err_in  = ERR_NONE;
               rsp_done_in = 1'b0;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (item_ff)
               ITEM_TICK: begin
                  if (cell_wait_ff != 8'd0) begin
                     cell_wait_in = cell_wait_ff - 8'd1;
                  end
                  if (aux_wait_ff != 8'd0) begin
                     aux_wait_in = aux_wait_ff - 8'd1;
                  end
                  finish = 1'b1;
               end
               ITEM_LOAD_CELL: begin
                  if (cell_load_ok) begin
                     cell_we                 = 1'b1;
                     cell_vld_in[cell_waddr] = 1'b1;
                  end
                  finish = 1'b1;
               end
               ITEM_LOAD_AUX: begin
                  if (aux_load_ok) begin
                     aux_we                = 1'b1;
                     aux_vld_in[aux_waddr] = 1'b1;
                  end
                  finish = 1'b1;
               end
               default: begin
                  if (phase_ff == PH_SEND) begin
                     rsp_mv_in = 1'b1;
                     if (inpec_ff) begin
                        rsp_byte_in = (pos_ff == 3'd0) ? pec_ff[15:8] : pec_ff[7:0];
                        adv         = 1'b1;
                     end else begin
                        state_in = S_SRD;
                     end
                  end else begin
                     if (inpec_ff) begin
                        if (pos_ff == 3'd0) begin
                           pec_in[15:8] = byte_ff;
                        end else begin
                           pec_in[7:0] = byte_ff;
                        end
                     end else if (phase_ff == PH_CMD) begin
                        if (pos_ff == 3'd0) begin
                           cmdbuf_in[15:8] = byte_ff;
                        end else begin
                           cmdbuf_in[7:0] = byte_ff;
                        end
                     end else if (recv_addr < CELL_BASE) begin
                        cfg_we                = 1'b1;
                        cfg_vld_in[cfg_waddr] = 1'b1;
                     end
                     adv = 1'b1;
                  end
               end
            endcase
         end
         S_SRD: begin
            state_in = S_SRDW;
         end
         S_SRDW: begin
            rsp_byte_in = win_byte;
            adv         = 1'b1;
         end
         S_CPHI: begin
            crc_ctl.go   = 1'b1;
            crc_ctl.data = cmdbuf_ff[15:8];
            state_in     = S_CPW1;
         end
         S_CPW1: begin
            if (!crc_sts.busy) begin
               crc_ctl.go   = 1'b1;
               crc_ctl.data = cmdbuf_ff[7:0];
               state_in     = S_CPW2;
            end
         end
         S_CPW2: begin
            if (!crc_sts.busy) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            finish = 1'b1;
            if ({crc_sts.rem, 1'b0} != pec_ff) begin
               rsp_err_in = ERR_PEC;
            end else if (cmdbuf_ff == cell_code_ff) begin
               cell_wait_in = conv_ms_ff;
            end else if (cmdbuf_ff == aux_code_ff) begin
               aux_wait_in = conv_ms_ff;
            end else if (cmdbuf_ff == CLR_CELL_CMD) begin
               cell_vld_in = '0;
            end else if (cmdbuf_ff == CLR_AUX_CMD) begin
               aux_vld_in = '0;
            end else if (cmd_hi < ADDR_MIN) begin
               rsp_err_in = ERR_ADDR;
            end else if ({1'b0, ic} >= 5'(CHIP_COUNT)) begin
               rsp_err_in = ERR_ADDR;
            end else if (cmd_lo == OP_WRCFG) begin
               phase_in = PH_RECV;
               wb_in    = cfg_base;
            end else if (cmd_lo == OP_RDCFG) begin
               phase_in     = PH_SEND;
               wb_in        = cfg_base;
               cnt_in       = 3'd0;
               crc_ctl.init = 1'b1;
               finish       = 1'b0;
               state_in     = S_WRD;
            end else if (cmd_lo inside {[OP_CELL_LO:OP_CELL_HI]}) begin
               if (cell_wait_ff != 8'd0) begin
                  rsp_err_in = ERR_NOT_READY;
               end else begin
                  phase_in     = PH_SEND;
                  wb_in        = cell_base;
                  cnt_in       = 3'd0;
                  crc_ctl.init = 1'b1;
                  finish       = 1'b0;
                  state_in     = S_WRD;
               end
            end else if (cmd_lo inside {[OP_AUX_LO:OP_AUX_HI]}) begin
               if (aux_wait_ff != 8'd0) begin
                  rsp_err_in = ERR_NOT_READY;
               end else begin
                  phase_in     = PH_SEND;
                  wb_in        = aux_base;
                  cnt_in       = 3'd0;
                  crc_ctl.init = 1'b1;
                  finish       = 1'b0;
                  state_in     = S_WRD;
               end
            end else begin
               rsp_err_in = ERR_CMD;
            end
         end
         S_WRD: begin
            state_in = S_WRDW;
         end
         S_WRDW: begin
            crc_ctl.go   = 1'b1;
            crc_ctl.data = win_byte;
            state_in     = S_WCRC;
         end
         S_WCRC: begin
            if (!crc_sts.busy) begin
               if (cnt_ff == 3'd5) begin
                  pec_in = {crc_sts.rem, 1'b0};
                  finish = 1'b1;
               end else begin
                  cnt_in   = cnt_ff + 3'd1;
                  state_in = S_WRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (adv) begin
         finish = 1'b1;
         if (!inpec_ff) begin
            if (pos_next >= limit) begin
               inpec_in = 1'b1;
               pos_in   = 3'd0;
            end else begin
               pos_in = pos_next;
            end
         end else if (pos_next >= 3'd2) begin
            phase_in = PH_CMD;
            pos_in   = 3'd0;
            inpec_in = 1'b0;
            wb_in    = '0;
            if (phase_ff == PH_CMD) begin
               rsp_done_in  = 1'b1;
               crc_ctl.init = 1'b1;
               finish       = 1'b0;
               state_in     = S_CPHI;
            end
         end else begin
            pos_in = pos_next;
         end
      end

      if (finish) begin
         state_in = S_IDLE;
      end
      rsp_valid_in = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_CMD;
         pos_ff       <= 3'd0;
         inpec_ff     <= 1'b0;
         cnt_ff       <= 3'd0;
         cell_wait_ff <= 8'd0;
         aux_wait_ff  <= 8'd0;
         cfg_vld_ff   <= '0;
         cell_vld_ff  <= '0;
         aux_vld_ff   <= '0;
         cell_code_ff <= 16'h0360;
         aux_code_ff  <= 16'h0560;
         conv_ms_ff   <= 8'd3;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         inpec_ff     <= inpec_in;
         cnt_ff       <= cnt_in;
         cell_wait_ff <= cell_wait_in;
         aux_wait_ff  <= aux_wait_in;
         cfg_vld_ff   <= cfg_vld_in;
         cell_vld_ff  <= cell_vld_in;
         aux_vld_ff   <= aux_vld_in;
         cell_code_ff <= cell_code_in;
         aux_code_ff  <= aux_code_in;
         conv_ms_ff   <= conv_ms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      byte_ff      <= byte_in;
      chip_ff      <= chip_in;
      chan_ff      <= chan_in;
      sample_ff    <= sample_in;
      cmdbuf_ff    <= cmdbuf_in;
      pec_ff       <= pec_in;
      wb_ff        <= wb_in;
      rsp_mv_ff    <= rsp_mv_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_done_ff  <= rsp_done_in;
      rd_region_ff <= rd_region_in;
      rd_sel_ff    <= rd_sel_in;
      rd_vld_ff    <= rd_vld_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_miso_valid   = rsp_mv_ff;
   assign rsp_miso_byte    = rsp_byte_ff;
   assign rsp_error_code   = rsp_err_ff;
   assign rsp_command_done = rsp_done_ff;
endmodule

/* rtl/bmsp_checker.sv */
`timescale 1ns / 1ps
// port-level checks of the battery monitor spi slave and their bind
module bmsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_miso_valid,
   input logic [7:0] rsp_miso_byte,
   input logic [2:0] rsp_error_code,
   input logic       rsp_command_done
);
   import bmsp_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_err_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_NONE) |-> rsp_command_done)
      else $error("error reported outside a command frame end");

   a_miso_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_miso_valid) |-> (rsp_miso_byte == 8'd0))
      else $error("miso byte nonzero without miso valid");
endmodule

bind battery_monitor_spi_slave bmsp_checker u_bmsp_checker (.*);
